/* sv/rau_pkg.sv */
// rau_pkg: widths, payload structs, opcodes and sequencer types
// for the rational arithmetic unit; no dependencies
package rau_pkg;

    localparam int WIDTH    = 16;
    localparam int MAG_W    = 2 * WIDTH;
    localparam int NUM_W    = 2 * WIDTH + 1;
    localparam int DEN_W    = 2 * WIDTH - 1;
    localparam int AW       = NUM_W;
    localparam int CNT_W    = $clog2(MAG_W);
    localparam int CNT_LAST = MAG_W - 1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic signed [WIDTH-1:0] left_numerator;
        logic signed [WIDTH-1:0] left_denominator;
        logic signed [WIDTH-1:0] right_numerator;
        logic signed [WIDTH-1:0] right_denominator;
    } t_in_item;

    typedef struct packed {
        logic signed [NUM_W-1:0] result_numerator;
        logic [DEN_W-1:0]        result_denominator;
        logic                    divide_by_zero;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_ADD,
        ST_MUL2,
        ST_GINIT,
        ST_GCD,
        ST_DLN,
        ST_DIVN,
        ST_DLD,
        ST_DIVD,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL0,
        CMD_MUL1,
        CMD_ADD,
        CMD_MUL2,
        CMD_GINIT,
        CMD_GCD,
        CMD_DLN,
        CMD_DIV,
        CMD_DLD
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic in_ready;
        logic out_load;
    } t_ctrl;

    typedef struct packed {
        logic addsub;
        logic gcd_done;
    } t_stat;

endpackage

/* sv/rau_alu.sv */
// rau_alu: shared add / magnitude-difference unit with compare
// depends on rau_pkg
module rau_alu (
    input  logic [rau_pkg::AW-1:0] i_x,
    input  logic [rau_pkg::AW-1:0] i_y,
    input  logic                   i_add,
    output logic [rau_pkg::AW-1:0] o_res,
    output logic                   o_ge
);

    logic [rau_pkg::AW-1:0] big_op;
    logic [rau_pkg::AW-1:0] sml_op;

    always_comb begin
        o_ge   = (i_x >= i_y);
        big_op = o_ge ? i_x : i_y;
        sml_op = o_ge ? i_y : i_x;
        o_res  = i_add ? (i_x + i_y) : (big_op - sml_op);
    end

endmodule

/* sv/rau_dp.sv */
// rau_dp: operand registers, shared multiplier, binary gcd and
// restoring divider datapath; depends on rau_pkg and rau_alu
module rau_dp (
    input  logic               i_clk,
    input  rau_pkg::t_in_item  i_in_item,
    input  rau_pkg::t_ctrl     i_ctrl,
    output rau_pkg::t_stat     o_stat,
    output rau_pkg::t_out_item o_result
);

    localparam int W  = rau_pkg::WIDTH;
    localparam int MW = rau_pkg::MAG_W;
    localparam int AW = rau_pkg::AW;
    localparam int NW = rau_pkg::NUM_W;
    localparam int DW = rau_pkg::DEN_W;

    // sign and magnitude of a two's complement field; with zero_one set, zero maps to +1
    function automatic logic [W:0] to_sm(logic [W-1:0] v, logic zero_one);
        logic         neg;
        logic [W-1:0] mag;
        neg = v[W-1];
        mag = neg ? W'(~v + 1'b1) : v;
        if (zero_one && (v == '0)) begin
            neg = 1'b0;
            mag = W'(1);
        end
        return {neg, mag};
    endfunction

    rau_pkg::t_op r_op;
    logic         r_sa, r_sb, r_sc, r_sd;
    logic [W-1:0] r_ma, r_mb, r_mc, r_md;
    logic         r_dbz;
    logic [MW-1:0] r_nm, r_dm, r_u, r_v, r_q;
    logic         r_nneg, r_dneg;
    logic [AW-1:0] r_r;

    logic [W:0]   ld_a, ld_b, ld_c, ld_d;
    logic         ld_sc;

    logic [W-1:0]  mul_x, mul_y;
    logic          mul_neg;
    logic [MW-1:0] mul_p;
    logic          mul_sgn;

    logic [AW-1:0] alu_x, alu_y, alu_res;
    logic          alu_add, alu_ge;
    logic [NW-1:0] num_ext;

    always_comb begin
        ld_a  = to_sm(i_in_item.left_numerator, 1'b0);
        ld_b  = to_sm(i_in_item.left_denominator, 1'b1);
        ld_c  = to_sm(i_in_item.right_numerator, 1'b0);
        ld_d  = to_sm(i_in_item.right_denominator, 1'b1);
        // subtract negates the right fraction, zero keeps a plus sign
        ld_sc = (i_in_item.op == rau_pkg::OP_SUB) ? ((ld_c[W-1:0] != '0) && !ld_c[W])
                                                  : ld_c[W];
    end

    // shared multiplier operand select
    always_comb begin
        mul_x   = r_ma;
        mul_y   = r_md;
        mul_neg = r_sa ^ r_sd;
        case (i_ctrl.cmd)
            rau_pkg::CMD_MUL0: begin
                if (r_op == rau_pkg::OP_MUL) begin
                    mul_y   = r_mc;
                    mul_neg = r_sa ^ r_sc;
                end
            end
            rau_pkg::CMD_MUL1: begin
                mul_x = r_mb;
                if (r_op == rau_pkg::OP_MUL) begin
                    mul_y   = r_md;
                    mul_neg = r_sb ^ r_sd;
                end else begin
                    mul_y   = r_mc;
                    mul_neg = r_sb ^ r_sc;
                end
            end
            rau_pkg::CMD_MUL2: begin
                mul_x   = r_mb;
                mul_y   = r_md;
                mul_neg = r_sb ^ r_sd;
            end
            default: ;
        endcase
        mul_p   = MW'(mul_x) * MW'(mul_y);
        mul_sgn = mul_neg && (mul_p != '0);
    end

    // shared alu operand select
    always_comb begin
        alu_x   = {1'b0, r_nm};
        alu_y   = {1'b0, r_dm};
        alu_add = 1'b0;
        case (i_ctrl.cmd)
            rau_pkg::CMD_ADD: begin
                alu_add = (r_nneg == r_dneg);
            end
            rau_pkg::CMD_GCD: begin
                alu_x = {1'b0, r_u};
                alu_y = {1'b0, r_v};
            end
            rau_pkg::CMD_DIV: begin
                alu_x = {r_r[AW-2:0], r_q[MW-1]};
                alu_y = {1'b0, r_u};
            end
            default: ;
        endcase
    end

    rau_alu u_alu (
        .i_x   (alu_x),
        .i_y   (alu_y),
        .i_add (alu_add),
        .o_res (alu_res),
        .o_ge  (alu_ge)
    );

    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            rau_pkg::CMD_LOAD: begin
                r_op  <= i_in_item.op;
                r_sa  <= ld_a[W];
                r_ma  <= ld_a[W-1:0];
                r_sb  <= ld_b[W];
                r_mb  <= ld_b[W-1:0];
                r_sc  <= ld_sc;
                r_mc  <= ld_c[W-1:0];
                r_sd  <= ld_d[W];
                r_md  <= ld_d[W-1:0];
                r_dbz <= (i_in_item.op == rau_pkg::OP_DIV) && (ld_c[W-1:0] == '0);
            end
            rau_pkg::CMD_MUL0: begin
                r_nm   <= mul_p;
                r_nneg <= mul_sgn;
            end
            rau_pkg::CMD_MUL1: begin
                // second cross term for add/sub, denominator otherwise
                r_dm   <= mul_p;
                r_dneg <= mul_sgn;
            end
            rau_pkg::CMD_ADD: begin
                r_nm <= alu_res[MW-1:0];
                if (!alu_add) begin
                    r_nneg <= alu_ge ? r_nneg : r_dneg;
                end
            end
            rau_pkg::CMD_MUL2: begin
                r_dm   <= mul_p;
                r_dneg <= mul_sgn;
            end
            rau_pkg::CMD_GINIT: begin
                if ((r_nm == '0) || r_dbz) begin
                    // zero result or division by zero: force 0/1
                    r_nm   <= '0;
                    r_dm   <= MW'(1);
                    r_u    <= MW'(1);
                    r_v    <= MW'(1);
                    r_nneg <= 1'b0;
                end else begin
                    r_u    <= r_nm;
                    r_v    <= r_dm;
                    r_nneg <= r_nneg ^ r_dneg;
                end
            end
            rau_pkg::CMD_GCD: begin
                if (!r_u[0] && !r_v[0]) begin
                    // common factor two comes straight off the dividends
                    r_u  <= r_u >> 1;
                    r_v  <= r_v >> 1;
                    r_nm <= r_nm >> 1;
                    r_dm <= r_dm >> 1;
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u != r_v) begin
                    if (alu_ge) begin
                        r_u <= alu_res[MW-1:0];
                    end else begin
                        r_v <= alu_res[MW-1:0];
                    end
                end
            end
            rau_pkg::CMD_DLN: begin
                r_q <= r_nm;
                r_r <= '0;
            end
            rau_pkg::CMD_DIV: begin
                r_r <= alu_ge ? alu_res : alu_x;
                r_q <= {r_q[MW-2:0], alu_ge};
            end
            rau_pkg::CMD_DLD: begin
                r_nm <= r_q;
                r_q  <= r_dm;
                r_r  <= '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.addsub   = (r_op == rau_pkg::OP_ADD) || (r_op == rau_pkg::OP_SUB);
        o_stat.gcd_done = r_u[0] && r_v[0] && (r_u == r_v);

        num_ext = {1'b0, r_nm};
        o_result.result_numerator   = r_nneg ? (~num_ext + 1'b1) : num_ext;
        o_result.result_denominator = r_q[DW-1:0];
        o_result.divide_by_zero     = r_dbz;
    end

endmodule

/* sv/rau_ctrl.sv */
// rau_ctrl: sequencer for the rational arithmetic unit, steps the
// shared multiplier, gcd loop and divider; depends on rau_pkg
module rau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_free,
    input  rau_pkg::t_stat i_stat,
    output rau_pkg::t_ctrl o_ctrl
);

    rau_pkg::t_state            r_state, n_state;
    logic [rau_pkg::CNT_W-1:0]  r_cnt;
    logic                       cnt_last;

    assign cnt_last = (r_cnt == rau_pkg::CNT_W'(rau_pkg::CNT_LAST));

    always_comb begin
        n_state = r_state;
        case (r_state)
            rau_pkg::ST_IDLE:  if (i_in_valid) begin n_state = rau_pkg::ST_MUL0; end
            rau_pkg::ST_MUL0:  n_state = rau_pkg::ST_MUL1;
            rau_pkg::ST_MUL1: begin
                n_state = i_stat.addsub ? rau_pkg::ST_ADD : rau_pkg::ST_GINIT;
            end
            rau_pkg::ST_ADD:   n_state = rau_pkg::ST_MUL2;
            rau_pkg::ST_MUL2:  n_state = rau_pkg::ST_GINIT;
            rau_pkg::ST_GINIT: n_state = rau_pkg::ST_GCD;
            rau_pkg::ST_GCD:   if (i_stat.gcd_done) begin n_state = rau_pkg::ST_DLN; end
            rau_pkg::ST_DLN:   n_state = rau_pkg::ST_DIVN;
            rau_pkg::ST_DIVN:  if (cnt_last) begin n_state = rau_pkg::ST_DLD; end
            rau_pkg::ST_DLD:   n_state = rau_pkg::ST_DIVD;
            rau_pkg::ST_DIVD:  if (cnt_last) begin n_state = rau_pkg::ST_DONE; end
            rau_pkg::ST_DONE:  if (i_out_free) begin n_state = rau_pkg::ST_IDLE; end
            default:           n_state = rau_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl.cmd      = rau_pkg::CMD_NONE;
        o_ctrl.in_ready = 1'b0;
        o_ctrl.out_load = 1'b0;
        case (r_state)
            rau_pkg::ST_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.cmd = rau_pkg::CMD_LOAD;
                end
            end
            rau_pkg::ST_MUL0:  o_ctrl.cmd = rau_pkg::CMD_MUL0;
            rau_pkg::ST_MUL1:  o_ctrl.cmd = rau_pkg::CMD_MUL1;
            rau_pkg::ST_ADD:   o_ctrl.cmd = rau_pkg::CMD_ADD;
            rau_pkg::ST_MUL2:  o_ctrl.cmd = rau_pkg::CMD_MUL2;
            rau_pkg::ST_GINIT: o_ctrl.cmd = rau_pkg::CMD_GINIT;
            rau_pkg::ST_GCD:   o_ctrl.cmd = rau_pkg::CMD_GCD;
            rau_pkg::ST_DLN:   o_ctrl.cmd = rau_pkg::CMD_DLN;
            rau_pkg::ST_DIVN:  o_ctrl.cmd = rau_pkg::CMD_DIV;
            rau_pkg::ST_DLD:   o_ctrl.cmd = rau_pkg::CMD_DLD;
            rau_pkg::ST_DIVD:  o_ctrl.cmd = rau_pkg::CMD_DIV;
            rau_pkg::ST_DONE:  o_ctrl.out_load = i_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                rau_pkg::ST_DLN:  r_cnt <= '0;
                rau_pkg::ST_DLD:  r_cnt <= '0;
                rau_pkg::ST_DIVN: r_cnt <= r_cnt + 1'b1;
                rau_pkg::ST_DIVD: r_cnt <= r_cnt + 1'b1;
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_ctrl.in_ready) |=> !o_ctrl.in_ready)
        else $error("sequencer still ready after taking an item");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rau_pkg::ST_DIVN && cnt_last) |=> (r_state == rau_pkg::ST_DLD))
        else $error("numerator division did not end after full bit count");

    a_load_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.out_load |=> o_ctrl.in_ready)
        else $error("sequencer not idle after handing off a result");
`endif

endmodule

/* sv/rational_arithmetic_unit.sv */
// rational_arithmetic_unit: top level, sequencer plus datapath plus
// output register; depends on rau_pkg, rau_ctrl, rau_dp, rau_alu
//
// usage:
//  - input channel i_in_valid / o_in_ready / i_in_item carries op and two
//    signed fractions; an item is taken when valid and ready are both high
//  - output channel o_out_valid / i_out_ready / o_out_item carries the
//    reduced numerator (signed), positive denominator and divide_by_zero
//  - one item at a time: o_in_ready is high only while the sequencer idles
//  - from accept to o_out_valid the sequencer runs MUL0 and MUL1 on the
//    shared 16x16 multiplier (add and sub also ADD and MUL2 on the adder
//    and multiplier), a gcd setup state, the binary gcd loop (one shift or
//    subtract per cycle), then two 32-step restoring divisions on the
//    shared subtractor with a setup state each, and a hand-off state
//  - no new item is taken until the last result has been handed off to
//    the output register
//  - a finished result sits in the output register; if the receiver
//    stalls the sequencer waits with the next result and does not take
//    a new item, so nothing is dropped
//  - synchronous active-low reset empties the output register and returns
//    the sequencer to idle; no clearing pass is needed
module rational_arithmetic_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rau_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rau_pkg::t_out_item o_out_item
);

    rau_pkg::t_ctrl     ctrl;
    rau_pkg::t_stat     stat;
    rau_pkg::t_out_item dp_result;
    logic               out_free;

    logic               r_out_valid;
    rau_pkg::t_out_item r_out_item;

    // output slot can take a new item when empty or being drained
    assign out_free = !r_out_valid || i_out_ready;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    rau_dp u_dp (
        .i_clk     (i_clk),
        .i_in_item (i_in_item),
        .i_ctrl    (ctrl),
        .o_stat    (stat),
        .o_result  (dp_result)
    );

    // output register, control part
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register, payload
    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out_item <= dp_result;
        end
    end

    assign o_in_ready  = ctrl.in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.result_denominator != '0))
        else $error("result denominator is zero");

    a_dbz_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.divide_by_zero) |->
            ((o_out_item.result_numerator == '0) &&
             (o_out_item.result_denominator == rau_pkg::DEN_W'(1))))
        else $error("divide by zero item is not 0/1");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an undelivered item");
`endif

endmodule

/* bench/rational_arithmetic_unit_tb.sv */
// rational_arithmetic_unit_tb: self-checking bench for the rational arithmetic unit
// drives fraction items through the valid/ready channels, predicts the reduced
// result of each one and compares it; depends on rau_pkg and rational_arithmetic_unit
module rational_arithmetic_unit_tb;

    localparam int N_RANDOM   = 1200;
    localparam int STALL_MAX  = 4000;
    localparam int DRAIN_WAIT = 250;

    localparam logic signed [rau_pkg::WIDTH-1:0] OPND_MIN =
        {1'b1, {(rau_pkg::WIDTH-1){1'b0}}};
    localparam logic signed [rau_pkg::WIDTH-1:0] OPND_MAX =
        {1'b0, {(rau_pkg::WIDTH-1){1'b1}}};

    // reduced fraction that one item must give
    function automatic rau_pkg::t_out_item reduce_fraction(rau_pkg::t_in_item it);
        longint             ln, ld, rn, rd, num, den, ga, gb, gt;
        rau_pkg::t_out_item r;
        ln = $signed(it.left_numerator);
        ld = $signed(it.left_denominator);
        rn = $signed(it.right_numerator);
        rd = $signed(it.right_denominator);
        // a zero denominator stands for one
        if (ld == 0) ld = 1;
        if (rd == 0) rd = 1;
        r.divide_by_zero = 1'b0;
        num = 0;
        den = 1;
        case (it.op)
            rau_pkg::OP_ADD: begin
                num = ln * rd + rn * ld;
                den = ld * rd;
            end
            rau_pkg::OP_SUB: begin
                num = ln * rd - rn * ld;
                den = ld * rd;
            end
            rau_pkg::OP_MUL: begin
                num = ln * rn;
                den = ld * rd;
            end
            default: begin
                // dividing by a zero fraction gives 0/1 with the flag up
                if (rn == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    num = ln * rd;
                    den = ld * rn;
                end
            end
        endcase
        // sign goes to the numerator
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        ga = (num < 0) ? -num : num;
        gb = den;
        while (gb != 0) begin
            gt = ga % gb;
            ga = gb;
            gb = gt;
        end
        num = num / ga;
        den = den / ga;
        r.result_numerator   = num[rau_pkg::NUM_W-1:0];
        r.result_denominator = den[rau_pkg::DEN_W-1:0];
        return r;
    endfunction

    class rational_scoreboard;
        rau_pkg::t_out_item reduced_q[$];
        int                 errors;
        int                 n_results;

        function new();
            errors    = 0;
            n_results = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void note_input(rau_pkg::t_in_item it);
            reduced_q.push_back(reduce_fraction(it));
        endfunction

        task check_result(rau_pkg::t_out_item got);
            rau_pkg::t_out_item want;
            n_results++;
            if (reduced_q.size() == 0) begin
                report($sformatf("result %0d (%0d/%0d) with nothing expected", n_results,
                                 got.result_numerator, got.result_denominator));
                return;
            end
            want = reduced_q.pop_front();
            if (got.result_numerator !== want.result_numerator)
                report($sformatf("result %0d numerator %0d, want %0d", n_results,
                                 got.result_numerator, want.result_numerator));
            if (got.result_denominator !== want.result_denominator)
                report($sformatf("result %0d denominator %0d, want %0d", n_results,
                                 got.result_denominator, want.result_denominator));
            if (got.divide_by_zero !== want.divide_by_zero)
                report($sformatf("result %0d divide_by_zero %b, want %b", n_results,
                                 got.divide_by_zero, want.divide_by_zero));
        endtask
    endclass

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    rau_pkg::t_in_item  in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    rau_pkg::t_out_item out_item;

    bit        steady    = 1'b0;
    int        stalled_cycles = 0;

    rational_scoreboard sb = new();

    rational_arithmetic_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stalls now and then, never during the steady stretch
    always @(posedge clk) begin
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 9);
    end

    // watch both channels, feed the scoreboard, count dead cycles
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_input(in_item);
            if (out_valid && out_ready)
                sb.check_result(out_item);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled_cycles <= 0;
            else
                stalled_cycles <= stalled_cycles + 1;
        end
    end

    // watchdog
    initial begin
        while (stalled_cycles < STALL_MAX)
            @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_item(input rau_pkg::t_in_item it);
        while (!steady && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_fraction(input rau_pkg::t_op op, input int ln, input int ld,
                                 input int rn, input int rd);
        rau_pkg::t_in_item it;
        it.op                = op;
        it.left_numerator    = ln[rau_pkg::WIDTH-1:0];
        it.left_denominator  = ld[rau_pkg::WIDTH-1:0];
        it.right_numerator   = rn[rau_pkg::WIDTH-1:0];
        it.right_denominator = rd[rau_pkg::WIDTH-1:0];
        send_item(it);
    endtask

    // hold the sender back until every result is out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.reduced_q.size() != 0)
            @(posedge clk);
    endtask

    // mostly full-range values, with extremes and small ones mixed in
    function automatic logic signed [rau_pkg::WIDTH-1:0] random_operand();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            case ($urandom_range(4))
                0:       return OPND_MIN;
                1:       return OPND_MAX;
                2:       return '0;
                3:       return rau_pkg::WIDTH'(1);
                default: return rau_pkg::WIDTH'(-1);
            endcase
        end
        if (pick < 30)
            return rau_pkg::WIDTH'($signed($urandom_range(16)) - 8);
        return rau_pkg::WIDTH'($urandom);
    endfunction

    initial begin
        rau_pkg::t_in_item it;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: plain cases, signs, extremes
        send_fraction(rau_pkg::OP_ADD, 1, 2, 1, 3);
        send_fraction(rau_pkg::OP_SUB, 1, 2, 1, 3);
        send_fraction(rau_pkg::OP_MUL, 2, 3, 9, 4);
        send_fraction(rau_pkg::OP_DIV, 2, 3, 4, 9);
        send_fraction(rau_pkg::OP_ADD, 1, -2, 1, -3);
        send_fraction(rau_pkg::OP_DIV, -5, 7, 3, -11);
        send_fraction(rau_pkg::OP_ADD, OPND_MIN, OPND_MAX, OPND_MIN, OPND_MAX);
        send_fraction(rau_pkg::OP_SUB, OPND_MAX, OPND_MIN, OPND_MIN, OPND_MAX);
        send_fraction(rau_pkg::OP_MUL, OPND_MIN, 1, OPND_MIN, 1);
        send_fraction(rau_pkg::OP_MUL, 1, OPND_MIN, 1, OPND_MIN);
        send_fraction(rau_pkg::OP_DIV, OPND_MIN, 1, 1, OPND_MIN);
        send_fraction(rau_pkg::OP_DIV, OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX);
        // zero denominators count as one
        send_fraction(rau_pkg::OP_ADD, 3, 0, 5, 0);
        send_fraction(rau_pkg::OP_MUL, -7, 0, 3, 0);
        // divide by a zero numerator
        send_fraction(rau_pkg::OP_DIV, 7, 3, 0, 5);
        send_fraction(rau_pkg::OP_DIV, 0, 0, 0, 0);
        send_fraction(rau_pkg::OP_DIV, OPND_MIN, OPND_MIN, 0, OPND_MIN);
        // zero results, then a sum of two negative-over-negative fractions
        send_fraction(rau_pkg::OP_SUB, 5, 7, 5, 7);
        send_fraction(rau_pkg::OP_MUL, 0, -3, 4, 5);
        send_fraction(rau_pkg::OP_ADD, 0, 0, 0, 0);
        send_fraction(rau_pkg::OP_SUB, 0, 0, 0, 0);
        send_fraction(rau_pkg::OP_ADD, -1, -1, -1, -1);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 0 || i == 900)
                wait_drained();
            steady <= (i >= 400 && i < 700);
            it.op                = rau_pkg::t_op'($urandom_range(3));
            it.left_numerator    = random_operand();
            it.left_denominator  = random_operand();
            it.right_numerator   = random_operand();
            it.right_denominator = random_operand();
            send_item(it);
        end

        steady <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.reduced_q.size() != 0)
            sb.report($sformatf("%0d results never came", sb.reduced_q.size()));

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
sv/rau_pkg.sv
sv/rau_alu.sv
sv/rau_dp.sv
sv/rau_ctrl.sv
sv/rational_arithmetic_unit.sv
bench/rational_arithmetic_unit_tb.sv
